[hw/rtl/yrr_pkg.sv]
// Shared types, command codes and a helper function for the YUV 4:2:0 rotating reader.
package yrr_pkg;

    localparam logic [1:0] CMD_LUMA   = 2'd0;
    localparam logic [1:0] CMD_CHROMA = 2'd1;
    localparam logic [1:0] CMD_EMIT   = 2'd2;

    localparam logic [1:0] REG_ROT    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] col;
        logic [5:0] row;
        logic [7:0] luma_sample;
        logic [7:0] cb_sample;
        logic [7:0] cr_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] luma_out;
        logic [7:0] chan_one;
        logic [7:0] chan_two;
        logic [7:0] chan_three;
        logic [5:0] dest_col;
        logic [5:0] dest_row;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] rotation_quarter;
        logic [6:0] src_width;
        logic [6:0] src_height;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_emit;
        logic out_valid;
    } t_dp_status;

    function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 11'sd0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/yrr_regs.sv]
// Configuration register file behind the APB-style port.
module yrr_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output yrr_pkg::t_cfg o_cfg
);

    logic [1:0] r_rot;
    logic [6:0] r_width;
    logic [6:0] r_height;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot    <= 2'd0;
            r_width  <= 7'd64;
            r_height <= 7'd64;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                yrr_pkg::REG_ROT:    r_rot    <= pwdata[1:0];
                yrr_pkg::REG_WIDTH:  r_width  <= pwdata[6:0];
                yrr_pkg::REG_HEIGHT: r_height <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            yrr_pkg::REG_ROT:    prdata = {30'd0, r_rot};
            yrr_pkg::REG_WIDTH:  prdata = {25'd0, r_width};
            yrr_pkg::REG_HEIGHT: prdata = {25'd0, r_height};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.rotation_quarter = r_rot;
    assign o_cfg.src_width        = r_width;
    assign o_cfg.src_height       = r_height;

endmodule

[hw/rtl/yrr_ctrl.sv]
// Controller state machine: sequences each emit through read and convert steps.
module yrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  yrr_pkg::t_dp_status i_status,
    output yrr_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       out_free;

    // The output register can take a pixel when empty or when its transfer completes now.
    assign out_free = !i_status.out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd.take     = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.out_load = 1'b0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_status.in_emit) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/yrr_datapath.sv]
// Datapath: sample stores, output counters, rotation mapping, color math and output register.
module yrr_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  yrr_pkg::t_cfg       i_cfg,
    input  yrr_pkg::t_in_item   i_in_item,
    input  logic                i_out_stall,
    input  yrr_pkg::t_dp_cmd    i_cmd,
    output yrr_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output yrr_pkg::t_out_item  o_out_item
);

    localparam int CHROMA_W   = (MAX_WIDTH + 1) / 2;
    localparam int CHROMA_H   = (MAX_HEIGHT + 1) / 2;
    localparam int LUMA_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHR_DEPTH  = CHROMA_W * CHROMA_H;
    localparam int LAW        = (LUMA_DEPTH > 1) ? $clog2(LUMA_DEPTH) : 1;
    localparam int CAW        = (CHR_DEPTH > 1) ? $clog2(CHR_DEPTH) : 1;
    localparam logic [6:0] LIM_W = 7'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
    localparam logic [6:0] LIM_H = 7'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);

    logic [7:0]  luma_mem   [LUMA_DEPTH];
    logic [15:0] chroma_mem [CHR_DEPTH];

    logic [6:0]     r_col_cnt;
    logic [6:0]     r_row_cnt;
    logic [LAW-1:0] r_laddr;
    logic [CAW-1:0] r_caddr;
    logic [5:0]     r_x;
    logic [5:0]     r_y;
    logic           r_last;
    logic [7:0]     r_luma;
    logic [15:0]    r_chroma;
    logic           r_out_valid;
    yrr_pkg::t_out_item r_out;

    logic [6:0]  w;
    logic [6:0]  h;
    logic [6:0]  dw;
    logic [6:0]  dh;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [7:0]  row_adv;
    logic [7:0]  x_inc;
    logic [7:0]  y_inc;
    logic [6:0]  n_col_cnt;
    logic [6:0]  n_row_cnt;
    logic [6:0]  xi;
    logic [6:0]  yi;
    logic        is_emit;
    logic        luma_ok;
    logic        chroma_ok;
    logic [LAW-1:0] luma_wa;
    logic [CAW-1:0] chroma_wa;
    logic [LAW-1:0] luma_ra;
    logic [CAW-1:0] chroma_ra;
    logic signed [10:0] s_one;
    logic signed [10:0] s_two;
    logic signed [10:0] s_three;

    assign is_emit = (i_in_item.command == yrr_pkg::CMD_EMIT);

    // Effective frame size: zero acts as one, oversize acts as the store limit.
    always_comb begin
        w = (i_cfg.src_width == 7'd0) ? 7'd1 :
            ((i_cfg.src_width > LIM_W) ? LIM_W : i_cfg.src_width);
        h = (i_cfg.src_height == 7'd0) ? 7'd1 :
            ((i_cfg.src_height > LIM_H) ? LIM_H : i_cfg.src_height);
        dw = i_cfg.rotation_quarter[0] ? h : w;
        dh = i_cfg.rotation_quarter[0] ? w : h;
    end

    // Wrap counters left beyond the frame by a size or rotation change.
    always_comb begin
        row_adv = (r_col_cnt >= dw) ? ({1'b0, r_row_cnt} + 8'd1) : {1'b0, r_row_cnt};
        x       = (r_col_cnt >= dw) ? 7'd0 : r_col_cnt;
        y       = (row_adv >= {1'b0, dh}) ? 7'd0 : row_adv[6:0];
        x_inc   = {1'b0, x} + 8'd1;
        y_inc   = {1'b0, y} + 8'd1;
        n_col_cnt = x_inc[6:0];
        n_row_cnt = y;
        if (x_inc >= {1'b0, dw}) begin
            n_col_cnt = 7'd0;
            n_row_cnt = (y_inc >= {1'b0, dh}) ? 7'd0 : y_inc[6:0];
        end
    end

    // Map the destination position back to its source position.
    always_comb begin
        unique case (i_cfg.rotation_quarter)
            2'd0: begin
                xi = x;
                yi = y;
            end
            2'd1: begin
                xi = y;
                yi = h - 7'd1 - x;
            end
            2'd2: begin
                xi = w - 7'd1 - x;
                yi = h - 7'd1 - y;
            end
            default: begin
                xi = w - 7'd1 - y;
                yi = x;
            end
        endcase
    end

    always_comb begin
        luma_ok   = (int'(i_in_item.col) < MAX_WIDTH) && (int'(i_in_item.row) < MAX_HEIGHT);
        chroma_ok = (int'(i_in_item.col) < CHROMA_W) && (int'(i_in_item.row) < CHROMA_H);
        luma_wa   = LAW'(LAW'(i_in_item.row) * LAW'(MAX_WIDTH) + LAW'(i_in_item.col));
        chroma_wa = CAW'(CAW'(i_in_item.row) * CAW'(CHROMA_W) + CAW'(i_in_item.col));
        luma_ra   = LAW'(LAW'(yi) * LAW'(MAX_WIDTH) + LAW'(xi));
        chroma_ra = CAW'(CAW'(yi[6:1]) * CAW'(CHROMA_W) + CAW'(xi[6:1]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_item.command == yrr_pkg::CMD_LUMA) && luma_ok) begin
            luma_mem[luma_wa] <= i_in_item.luma_sample;
        end
        if (i_cmd.rd_en) begin
            r_luma <= luma_mem[r_laddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_item.command == yrr_pkg::CMD_CHROMA) && chroma_ok) begin
            chroma_mem[chroma_wa] <= {i_in_item.cb_sample, i_in_item.cr_sample};
        end
        if (i_cmd.rd_en) begin
            r_chroma <= chroma_mem[r_caddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= 7'd0;
            r_row_cnt <= 7'd0;
        end else if (i_cmd.take && is_emit) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_emit) begin
            r_laddr <= luma_ra;
            r_caddr <= chroma_ra;
            r_x     <= x[5:0];
            r_y     <= y[5:0];
            r_last  <= (x == dw - 7'd1) && (y == dh - 7'd1);
        end
    end

    always_comb begin
        s_one   = $signed({3'b000, r_luma}) + $signed({3'b000, r_chroma[15:8]}) - 11'sd128;
        s_two   = $signed({3'b000, r_luma}) - $signed({3'b000, r_chroma[15:8]})
                - $signed({3'b000, r_chroma[7:0]}) + 11'sd256;
        s_three = $signed({3'b000, r_luma}) + $signed({3'b000, r_chroma[7:0]}) - 11'sd128;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.luma_out   <= r_luma;
            r_out.chan_one   <= yrr_pkg::clamp_byte(s_one);
            r_out.chan_two   <= yrr_pkg::clamp_byte(s_two);
            r_out.chan_three <= yrr_pkg::clamp_byte(s_three);
            r_out.dest_col   <= r_x;
            r_out.dest_row   <= r_y;
            r_out.frame_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.in_emit   = is_emit;
    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

[hw/rtl/yuv420_rotate_to_rgb.sv]
// Top level of the YUV 4:2:0 frame store with rotating RGB-style reader.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) carries three commands:
// load a luma sample, load a chroma pair, or emit the next output pixel.
// Output channel (o_out_valid / i_out_stall / o_out_item) carries one pixel per
// emit, in destination raster order of the rotated frame.
// A load transfer writes the store, and the next item may follow in the next
// cycle. An emit passes through three steps (address, store read, color
// conversion), and the input stays stalled until the last of them is done, so
// the block takes no new item while an emit is in progress. Each store has a
// single, registered read port. o_out_valid rises when the converted pixel is
// loaded into the output register at the end of the conversion step.
// The output register holds a finished pixel while the receiver stalls, and
// loads keep being accepted meanwhile; a following emit waits in its last step
// until the register frees up.
// Reset clears the output counters, the output valid and the controller, and
// restores rotation 0 and a 64 by 64 frame. Sample stores are not cleared.
// Configuration: APB-style port, rotation at 0x0, width at 0x4, height at 0x8.
module yuv420_rotate_to_rgb #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  yrr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output yrr_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    yrr_pkg::t_cfg       cfg;
    yrr_pkg::t_dp_cmd    dp_cmd;
    yrr_pkg::t_dp_status dp_status;

    yrr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    yrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_in_stall  (o_in_stall)
    );

    yrr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[hw/rtl/yrr_checker.sv]
// Port-level checker for the rotating reader, bound to the top level.
module yrr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input yrr_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input yrr_pkg::t_out_item o_out_item,
    input logic               pready
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // A stalled pixel stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output pixel changed or dropped");

    // An emit occupies the block for the following cycle.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_item.command == yrr_pkg::CMD_EMIT) |=> o_in_stall)
        else $error("input accepted right after an emit");

    // Loads never hold the input channel.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_item.command != yrr_pkg::CMD_EMIT) |=> !o_in_stall)
        else $error("input stalled after a load");

    // No pixel is presented right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind yuv420_rotate_to_rgb yrr_checker u_yrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
